// ----- rtl/core/wmsp_pkg.sv -----
// ----------------------------------------------------------------------------
// wmsp_pkg
// Shared types and constants of the window max/sum pooling block.
// ----------------------------------------------------------------------------
`default_nettype none

package wmsp_pkg;

   // Stream geometry
   localparam int MAX_HEIGHT = 64;
   localparam int MAX_KERNEL = 8;
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int KCOL_W     = $clog2(MAX_KERNEL);
   localparam int RING_DEPTH = MAX_HEIGHT * MAX_KERNEL;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int COL_W      = 10;

   // Field widths
   localparam int SAMPLE_W   = 16;
   localparam int POOL_W     = 22;

   // Register widths
   localparam int KER_W      = 4;
   localparam int PH_W       = 7;
   localparam int PW_W       = 11;

   // Stride test: remainder taken over a 10-bit dividend, 5 bits per cycle
   localparam int DIV_W      = 10;
   localparam int STEP_W     = 5;
   localparam int REM_W      = 3;

   // APB port
   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 32;

   typedef enum logic [2:0] {
      REG_KERNEL_HEIGHT = 3'd0,
      REG_KERNEL_WIDTH  = 3'd1,
      REG_ROW_STRIDE    = 3'd2,
      REG_COL_STRIDE    = 3'd3,
      REG_PLANE_HEIGHT  = 3'd4,
      REG_PLANE_WIDTH   = 3'd5,
      REG_MAX_MODE      = 3'd6
   } csr_reg_type;

   // Clamped configuration as the datapath sees it
   typedef struct packed {
      logic [KER_W-1:0] kh;
      logic [KER_W-1:0] kw;
      logic [KER_W-1:0] rs;
      logic [KER_W-1:0] cs;
      logic [PH_W-1:0]  ph;
      logic [PW_W-1:0]  pw;
      logic             max_mode;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_MOD   = 3'd1,
      ST_WALK  = 3'd2,
      ST_DRAIN = 3'd3,
      ST_PUSH  = 3'd4
   } state_type;

   typedef struct packed {
      logic capture;
      logic walk_start;
      logic walk_read;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic close;
      logic walk_last;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ----- rtl/core/wmsp_if.sv -----
// ----------------------------------------------------------------------------
// wmsp_if
// Valid/ready channels of the pooling block: sample words in, pooled words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface wmsp_req_if;
   import wmsp_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       end_of_input;

   modport source (output valid, output sample, output end_of_input, input ready);
   modport sink   (input valid, input sample, input end_of_input, output ready);
endinterface

interface wmsp_rsp_if;
   import wmsp_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [POOL_W-1:0] pooled_value;
   logic                     plane_last;

   modport source (output valid, output pooled_value, output plane_last, input ready);
   modport sink   (input valid, input pooled_value, input plane_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wmsp_csr.sv -----
// ----------------------------------------------------------------------------
// wmsp_csr
// APB register file; presents clamped configuration to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module wmsp_csr
   import wmsp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output      logic [CSR_DW-1:0] prdata,
   output      logic              pready,
   output      cfg_type           cfg
);

   logic [KER_W-1:0] kh_ff, kw_ff, rs_ff, cs_ff;
   logic [PH_W-1:0]  ph_ff;
   logic [PW_W-1:0]  pw_ff;
   logic             mode_ff;
   logic             wr_en;
   csr_reg_type      idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = csr_reg_type'(paddr[CSR_AW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         kh_ff   <= KER_W'(2);
         kw_ff   <= KER_W'(2);
         rs_ff   <= KER_W'(2);
         cs_ff   <= KER_W'(2);
         ph_ff   <= PH_W'(32);
         pw_ff   <= PW_W'(32);
         mode_ff <= 1'b0;
      end else if (wr_en) begin
         unique case (idx)
            REG_KERNEL_HEIGHT: kh_ff   <= pwdata[KER_W-1:0];
            REG_KERNEL_WIDTH:  kw_ff   <= pwdata[KER_W-1:0];
            REG_ROW_STRIDE:    rs_ff   <= pwdata[KER_W-1:0];
            REG_COL_STRIDE:    cs_ff   <= pwdata[KER_W-1:0];
            REG_PLANE_HEIGHT:  ph_ff   <= pwdata[PH_W-1:0];
            REG_PLANE_WIDTH:   pw_ff   <= pwdata[PW_W-1:0];
            REG_MAX_MODE:      mode_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_KERNEL_HEIGHT: prdata = CSR_DW'(kh_ff);
         REG_KERNEL_WIDTH:  prdata = CSR_DW'(kw_ff);
         REG_ROW_STRIDE:    prdata = CSR_DW'(rs_ff);
         REG_COL_STRIDE:    prdata = CSR_DW'(cs_ff);
         REG_PLANE_HEIGHT:  prdata = CSR_DW'(ph_ff);
         REG_PLANE_WIDTH:   prdata = CSR_DW'(pw_ff);
         REG_MAX_MODE:      prdata = CSR_DW'(mode_ff);
         default:           prdata = '0;
      endcase
   end

   // Zero acts as one, anything past the bound acts as the bound
   function automatic logic [KER_W-1:0] clamp_ker(input logic [KER_W-1:0] v);
      if (v == '0)
         return KER_W'(1);
      if (v > KER_W'(MAX_KERNEL))
         return KER_W'(MAX_KERNEL);
      return v;
   endfunction

   always_comb begin
      cfg.kh       = clamp_ker(kh_ff);
      cfg.kw       = clamp_ker(kw_ff);
      cfg.rs       = clamp_ker(rs_ff);
      cfg.cs       = clamp_ker(cs_ff);
      cfg.ph       = (ph_ff == '0) ? PH_W'(1) :
                     (ph_ff > PH_W'(MAX_HEIGHT)) ? PH_W'(MAX_HEIGHT) : ph_ff;
      cfg.pw       = (pw_ff == '0) ? PW_W'(1) :
                     (pw_ff > PW_W'(1024)) ? PW_W'(1024) : pw_ff;
      cfg.max_mode = mode_ff;
   end

endmodule

`default_nettype wire

// ----- rtl/core/wmsp_datapath.sv -----
// ----------------------------------------------------------------------------
// wmsp_datapath
// Position counters, stride remainder lanes, column ring, window accumulator
// and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wmsp_datapath
   import wmsp_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cfg_type                    cfg,
   input  wire cmd_type                    cmd,
   output      sts_type                    sts,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   input  wire logic                       req_end_of_input,
   input  wire logic                       rsp_ready,
   output      logic                       rsp_valid,
   output      logic signed [POOL_W-1:0]   rsp_pooled_value,
   output      logic                       rsp_plane_last
);

   localparam int LANES = 4;

   // One remainder digit group: 5 shift/compare/subtract steps
   function automatic logic [REM_W-1:0] mod_step(input logic [REM_W-1:0]  rem_i,
                                                 input logic [STEP_W-1:0] bits_i,
                                                 input logic [KER_W-1:0]  div_i);
      logic [REM_W:0]   part;
      logic [REM_W-1:0] rem_v;
      rem_v = rem_i;
      for (int k = STEP_W - 1; k >= 0; k--) begin
         part = {rem_v, bits_i[k]};
         if (part >= div_i)
            part = part - div_i;
         rem_v = part[REM_W-1:0];
      end
      return rem_v;
   endfunction

   // Running position
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   // Position of the word in flight
   logic [ROW_W-1:0]  it_row_ff;
   logic [COL_W-1:0]  it_col_ff;

   logic [ROW_W:0]    row_sum;
   logic [COL_W:0]    col_sum;
   logic              row_fit, col_fit, plane_fit;
   logic              row_fit_ff, col_fit_ff, plane_fit_ff;

   // Lanes: 0 row offset / rs, 1 col offset / cs, 2 (ph-kh) / rs, 3 (pw-kw) / cs
   logic [DIV_W-1:0]  div   [LANES];
   logic [KER_W-1:0]  dvsr  [LANES];
   logic [REM_W-1:0]  rem_ff  [LANES];
   logic [STEP_W-1:0] lo_ff   [LANES];
   logic [REM_W-1:0]  rem_fin [LANES];

   logic [PH_W-1:0]   last_row;
   logic [PW_W-1:0]   last_col;
   logic              last_ff;

   // Column ring
   logic signed [SAMPLE_W-1:0] ring [RING_DEPTH];
   logic [RING_AW-1:0]         waddr, raddr;
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic                       rd_vld_ff;

   logic [KCOL_W-1:0]          a_ff, b_ff;
   logic                       first_ff;
   logic signed [POOL_W-1:0]   acc_ff, smp_ext;

   logic                       out_vld_ff;
   logic signed [POOL_W-1:0]   out_val_ff;
   logic                       out_last_ff;
   logic                       out_free;

   // ---- position and stride remainders ----
   assign row_sum   = {1'b0, row_ff} + (ROW_W+1)'(1);
   assign col_sum   = {1'b0, col_ff} + (COL_W+1)'(1);
   assign row_fit   = row_sum >= (ROW_W+1)'(cfg.kh);
   assign col_fit   = col_sum >= (COL_W+1)'(cfg.kw);
   assign plane_fit = (cfg.ph >= PH_W'(cfg.kh)) && (cfg.pw >= PW_W'(cfg.kw));

   assign div[0]  = DIV_W'(row_sum - (ROW_W+1)'(cfg.kh));
   assign div[1]  = DIV_W'(col_sum - (COL_W+1)'(cfg.kw));
   assign div[2]  = DIV_W'(cfg.ph - PH_W'(cfg.kh));
   assign div[3]  = DIV_W'(cfg.pw - PW_W'(cfg.kw));
   assign dvsr[0] = cfg.rs;
   assign dvsr[1] = cfg.cs;
   assign dvsr[2] = cfg.rs;
   assign dvsr[3] = cfg.cs;

   always_comb begin
      for (int i = 0; i < LANES; i++)
         rem_fin[i] = mod_step(rem_ff[i], lo_ff[i], dvsr[i]);
   end

   // Next position: wrap at plane end, restart after end of input
   always_comb begin
      row_in = row_sum[ROW_W-1:0];
      col_in = col_ff;
      if (row_sum >= (ROW_W+1)'(cfg.ph)) begin
         row_in = '0;
         col_in = (col_sum >= cfg.pw) ? '0 : col_sum[COL_W-1:0];
      end
      if (req_end_of_input) begin
         row_in = '0;
         col_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (cmd.capture) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         it_row_ff    <= row_ff;
         it_col_ff    <= col_ff;
         row_fit_ff   <= row_fit;
         col_fit_ff   <= col_fit;
         plane_fit_ff <= plane_fit;
         for (int i = 0; i < LANES; i++) begin
            rem_ff[i] <= mod_step('0, div[i][DIV_W-1:STEP_W], dvsr[i]);
            lo_ff[i]  <= div[i][STEP_W-1:0];
         end
      end
   end

   // Last window of the plane ends on row ph-1-(ph-kh)%rs, col pw-1-(pw-kw)%cs
   assign last_row = cfg.ph - PH_W'(1) - PH_W'(rem_fin[2]);
   assign last_col = cfg.pw - PW_W'(1) - PW_W'(rem_fin[3]);

   assign sts.close = row_fit_ff && col_fit_ff &&
                      (rem_fin[0] == '0) && (rem_fin[1] == '0);

   always_ff @(posedge clock) begin
      if (cmd.walk_start)
         last_ff <= plane_fit_ff &&
                    (PH_W'(it_row_ff) == last_row) && (PW_W'(it_col_ff) == last_col);
   end

   // ---- ring store ----
   assign waddr = {col_ff[KCOL_W-1:0], row_ff};
   assign raddr = {it_col_ff[KCOL_W-1:0] - b_ff, it_row_ff - ROW_W'(a_ff)};

   always_ff @(posedge clock) begin
      if (cmd.capture)
         ring[waddr] <= req_sample;
      if (cmd.walk_read)
         rd_data_ff <= ring[raddr];
   end

   // ---- window walk: rows inner, columns outer ----
   assign sts.walk_last = ({1'b0, a_ff} == cfg.kh - KER_W'(1)) &&
                          ({1'b0, b_ff} == cfg.kw - KER_W'(1));

   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         a_ff <= '0;
         b_ff <= '0;
      end else if (cmd.walk_read) begin
         if ({1'b0, a_ff} == cfg.kh - KER_W'(1)) begin
            a_ff <= '0;
            b_ff <= b_ff + KCOL_W'(1);
         end else begin
            a_ff <= a_ff + KCOL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rd_vld_ff <= 1'b0;
      else
         rd_vld_ff <= cmd.walk_read;
   end

   assign smp_ext = POOL_W'(rd_data_ff);

   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         first_ff <= 1'b1;
         acc_ff   <= '0;
      end else if (rd_vld_ff) begin
         first_ff <= 1'b0;
         if (cfg.max_mode) begin
            if (first_ff || (smp_ext > acc_ff))
               acc_ff <= smp_ext;
         end else begin
            acc_ff <= acc_ff + smp_ext;
         end
      end
   end

   // ---- result register ----
   assign out_free     = !out_vld_ff || rsp_ready;
   assign sts.out_free = out_free;

   always_ff @(posedge clock) begin
      if (reset)
         out_vld_ff <= 1'b0;
      else if (cmd.load_out)
         out_vld_ff <= 1'b1;
      else if (rsp_ready)
         out_vld_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_val_ff  <= acc_ff;
         out_last_ff <= last_ff;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_pooled_value = out_val_ff;
   assign rsp_plane_last   = out_last_ff;

endmodule

`default_nettype wire

// ----- rtl/core/wmsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// wmsp_ctrl
// Sequencer: take a word, finish the stride test, walk the window, push.
// ----------------------------------------------------------------------------
`default_nettype none

module wmsp_ctrl
   import wmsp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   output      cmd_type cmd,
   input  wire sts_type sts
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_MOD;
         ST_MOD:   state_in = sts.close ? ST_WALK : ST_IDLE;
         ST_WALK:  if (sts.walk_last) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_PUSH;
         ST_PUSH:  if (sts.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      cmd.capture    = (state_ff == ST_IDLE) && req_valid;
      cmd.walk_start = (state_ff == ST_MOD) && sts.close;
      cmd.walk_read  = (state_ff == ST_WALK);
      cmd.load_out   = (state_ff == ST_PUSH) && sts.out_free;
   end

   a_capture_to_mod: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == ST_MOD)
      else $error("accepted word did not enter the stride test");

   a_no_close_back_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD && !sts.close) |=> state_ff == ST_IDLE)
      else $error("word without result did not release the input");

   a_walk_to_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && sts.walk_last) |=> ##1 state_ff == ST_PUSH)
      else $error("window walk did not reach the push state");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.out_free)
      else $error("result loaded over an untaken result");

endmodule

`default_nettype wire

// ----- rtl/core/window_max_or_sum_pooling.sv -----
// Sequence: a word that closes no window is accepted and passes the stride test;
//   a closing word then walks the window, drains, and loads the result register.
// Flow: one word in flight at a time; a closing word takes one ring read per
//   window element, as the ring has a single read port.
// Reset: synchronous, active high; clears position counters, sequencer, result
//   valid and restores register defaults. The ring store is not cleared.
// ----------------------------------------------------------------------------
// window_max_or_sum_pooling
// Streaming 2-D pooling over column-major planes: window maximum or exact sum.
// ----------------------------------------------------------------------------
`default_nettype none

module window_max_or_sum_pooling
   import wmsp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // sample words in
   wmsp_req_if.sink               req_ch,
   // pooled words out
   wmsp_rsp_if.source             rsp_ch,
   // APB register port
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output      logic [CSR_DW-1:0] prdata,
   output      logic              pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   // Registers. Out-of-range values are clamped here, so the datapath only
   // ever sees kernels/strides 1..8, plane height 1..64, width 1..1024.
   wmsp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer. One word in flight at a time:
   //   IDLE  - input ready; accept writes the ring and runs the upper
   //           remainder digits of the four stride lanes
   //   MOD   - lower digits; decides whether the word closes a window
   //   WALK  - one ring read per window element
   //   DRAIN - last read lands in the accumulator
   //   PUSH  - move into the result register once it is free
   wmsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Datapath. Ring entry = (col mod 8)*64 + row, so the last eight columns
   // of up to 64 rows stay available for the window walk. The result
   // register lets the next word in while a result waits downstream.
   wmsp_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .sts              (sts),
      .req_sample       (req_ch.sample),
      .req_end_of_input (req_ch.end_of_input),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_pooled_value (rsp_ch.pooled_value),
      .rsp_plane_last   (rsp_ch.plane_last)
   );

endmodule

`default_nettype wire
